// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/apq_pkg.sv =====
// ----------------------------------------------------------------------------
// Aging priority queue package
// Command and status codes of the aging priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package apq_pkg;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_CLOSED  = 3'd3,
		ST_BADPRIO = 3'd4
	} status_t;

	typedef enum logic {
		CMD_INSERT   = 1'b0,
		CMD_RETRIEVE = 1'b1
	} cmd_t;

	localparam int STATUS_W = 3;

endpackage

`default_nettype wire

// ===== rtl/aging_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Aging priority queue
// Bounded queue of (id, priority) entries served lowest number first, with
// aging of the waiting entries on every successful retrieve.
// ----------------------------------------------------------------------------
// Entries sit in one RAM as a ring kept sorted by priority number, oldest
// first among equal numbers. One RAM port pair is walked by a small sequencer,
// one entry per cycle, and the block takes no new transaction until the
// current one has finished. An insert shifts larger-numbered entries back
// from the tail and places the new one; a retrieve reads the head and ages
// the rest; a rejected command goes to the reply. The result transaction waits
// in an output register until taken. The user must write the closed register
// through the cfg channel only while idle; the block itself does not check.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module aging_priority_queue
	import apq_pkg::*;
#(
	parameter int DEPTH        = 16,
	parameter int ID_MAX       = 1023,
	parameter int PRIORITY_MAX = 15,
	localparam int ID_W  = $clog2(ID_MAX + 1),
	localparam int PRI_W = $clog2(PRIORITY_MAX + 1),
	localparam int CNT_W = $clog2(DEPTH + 1),
	localparam int IN_W  = ((ID_W + PRI_W + 7) / 8) * 8,
	localparam int OUT_W = ((ID_W + STATUS_W + CNT_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_data,    // closed
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,     // entry_id, entry_priority
	input  logic             s_tuser,     // cmd
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,     // out_id, status, occupancy
	output logic             m_tuser      // id_valid
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ENT_W = ID_W + PRI_W;

	localparam logic [ID_W-1:0]  ID_MAX_C  = ID_W'(ID_MAX);
	localparam logic [PRI_W-1:0] PRI_MAX_C = PRI_W'(PRIORITY_MAX);
	localparam logic [PRI_W-1:0] PRI_ONE_C = PRI_W'(1);
	localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE_C = CNT_W'(1);
	localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
	localparam logic [PTR_W-1:0] PTR_ONE_C = PTR_W'(1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_PLACE,
		S_RHEAD,
		S_AGE,
		S_RESP
	} state_t;

	function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_LAST : p - PTR_ONE_C;
	endfunction

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PTR_ONE_C;
	endfunction

	state_t             state_q;
	logic [PTR_W-1:0]   head_q;
	logic [PTR_W-1:0]   tail_q;
	logic [CNT_W-1:0]   count_q;
	logic [PTR_W-1:0]   pos_q;
	logic [CNT_W-1:0]   left_q;
	logic [ID_W-1:0]    new_id_q;
	logic [PRI_W-1:0]   new_pri_q;
	logic               res_valid_q;
	logic [ID_W-1:0]    res_id_q;
	status_t            res_status_q;
	logic               closed_q;
	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;
	logic               m_tuser_q;

	logic [ID_W-1:0]    in_id;
	logic [PRI_W-1:0]   in_pri;
	logic               in_bad;
	logic               accept;

	logic               we;
	logic [PTR_W-1:0]   waddr;
	logic [ENT_W-1:0]   wdata;
	logic [PTR_W-1:0]   raddr;
	logic [ENT_W-1:0]   rdata;
	logic [ID_W-1:0]    rd_id;
	logic [PRI_W-1:0]   rd_pri;
	logic [PRI_W-1:0]   aged_pri;
	logic               shift_back;

	assign in_id      = s_tdata[ID_W-1:0];
	assign in_pri     = s_tdata[ID_W +: PRI_W];
	assign in_bad     = (in_pri == '0) || (in_pri > PRI_MAX_C) || (in_id > ID_MAX_C);
	assign accept     = s_tvalid && s_tready;
	assign rd_id      = rdata[ID_W-1:0];
	assign rd_pri     = rdata[ID_W +: PRI_W];
	assign aged_pri   = (rd_pri > PRI_ONE_C) ? rd_pri - PRI_ONE_C : rd_pri;
	assign shift_back = rd_pri > new_pri_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	always_comb begin
		raddr = ring_prev(tail_q);
		we    = 1'b0;
		waddr = pos_q;
		wdata = {new_pri_q, new_id_q};
		case (state_q)
			S_IDLE: begin
				raddr = (cmd_t'(s_tuser) == CMD_RETRIEVE) ? head_q : ring_prev(tail_q);
			end
			S_WALK: begin
				raddr = ring_prev(ring_prev(pos_q));
				we    = 1'b1;
				wdata = shift_back ? rdata : {new_pri_q, new_id_q};
			end
			S_PLACE: begin
				we = 1'b1;
			end
			S_RHEAD: begin
				raddr = ring_next(head_q);
			end
			S_AGE: begin
				raddr = ring_next(pos_q);
				we    = 1'b1;
				wdata = {aged_pri, rd_id};
			end
			default: begin
				raddr = ring_prev(tail_q);
			end
		endcase
	end

	apq_ram #(
		.WIDTH(ENT_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			pos_q        <= '0;
			left_q       <= '0;
			new_id_q     <= '0;
			new_pri_q    <= '0;
			res_valid_q  <= 1'b0;
			res_id_q     <= '0;
			res_status_q <= ST_OK;
			closed_q     <= 1'b0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tuser_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				closed_q <= cfg_data;
			end
			if (m_tvalid_q && m_tready && state_q != S_RESP) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						new_id_q    <= in_id;
						new_pri_q   <= in_pri;
						res_valid_q <= 1'b0;
						res_id_q    <= '0;
						if (cmd_t'(s_tuser) == CMD_INSERT) begin
							if (in_bad) begin
								res_status_q <= ST_BADPRIO;
								state_q      <= S_RESP;
							end else if (closed_q) begin
								res_status_q <= ST_CLOSED;
								state_q      <= S_RESP;
							end else if (count_q >= DEPTH_C) begin
								res_status_q <= ST_FULL;
								state_q      <= S_RESP;
							end else begin
								res_status_q <= ST_OK;
								pos_q        <= tail_q;
								state_q      <= (count_q == '0) ? S_PLACE : S_WALK;
							end
						end else begin
							if (closed_q) begin
								res_status_q <= ST_CLOSED;
								state_q      <= S_RESP;
							end else if (count_q == '0) begin
								res_status_q <= ST_EMPTY;
								state_q      <= S_RESP;
							end else begin
								res_status_q <= ST_OK;
								state_q      <= S_RHEAD;
							end
						end
					end
				end
				S_WALK: begin
					if (shift_back) begin
						pos_q <= ring_prev(pos_q);
						if (ring_prev(pos_q) == head_q) begin
							state_q <= S_PLACE;
						end
					end else begin
						tail_q  <= ring_next(tail_q);
						count_q <= count_q + CNT_ONE_C;
						state_q <= S_RESP;
					end
				end
				S_PLACE: begin
					tail_q  <= ring_next(tail_q);
					count_q <= count_q + CNT_ONE_C;
					state_q <= S_RESP;
				end
				S_RHEAD: begin
					res_valid_q <= 1'b1;
					res_id_q    <= rd_id;
					head_q      <= ring_next(head_q);
					count_q     <= count_q - CNT_ONE_C;
					if (count_q == CNT_ONE_C) begin
						state_q <= S_RESP;
					end else begin
						pos_q   <= ring_next(head_q);
						left_q  <= count_q - CNT_ONE_C;
						state_q <= S_AGE;
					end
				end
				S_AGE: begin
					pos_q  <= ring_next(pos_q);
					left_q <= left_q - CNT_ONE_C;
					if (left_q == CNT_ONE_C) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= OUT_W'({count_q, res_status_q, res_id_q});
						m_tuser_q  <= res_valid_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_IMPLY(a_count_bound, clk, arst_n, 1'b1, count_q <= DEPTH_C, "count above depth")
	`ASSERT_IMPLY(a_empty_ring, clk, arst_n, count_q == '0, head_q == tail_q, "empty ring skewed")
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, !s_tready, "ready after accept")
	`ASSERT_IMPLY(a_id_ok, clk, arst_n, m_tvalid && m_tuser, m_tdata[ID_W +: STATUS_W] == ST_OK, "id with bad status")
	`ASSERT_IMPLY(a_write_state, clk, arst_n, we, state_q != S_IDLE && state_q != S_RESP, "stray write")

endmodule

`default_nettype wire

// ===== rtl/apq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module apq_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== test/apq_checker.sv =====
// ----------------------------------------------------------------------------
// Aging priority queue checker
// Watches the command, result and cfg channels of the aging priority queue,
// keeps its own sorted ring of entries with aging on retrieve, and compares
// every result transaction field by field with the oldest predicted reply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apq_checker
	import apq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic        m_tuser,
	output int          fails,
	output int          pending
);

	localparam int SLOTS = 16;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic       id_valid;
		logic [9:0] out_id;
		status_t    status;
		logic [4:0] occupancy;
	} queue_reply_t;

	logic [9:0] slot_id [SLOTS];
	logic [3:0] slot_pri [SLOTS];
	logic [3:0] head_q = '0;
	logic [3:0] tail_q = '0;
	logic [4:0] count_q = '0;
	logic       closed_q = 1'b0;

	queue_reply_t awaited_replies [$];
	int           fail_count = 0;

	function automatic queue_reply_t predict_queue_op(cmd_t cmd, logic [9:0] id,
			logic [3:0] pri);
		queue_reply_t r;
		logic [3:0]   pos;
		logic [3:0]   prev;
		int           i;
		r = '0;
		r.status = ST_OK;
		if (cmd == CMD_INSERT) begin
			if (pri == 4'd0) begin
				r.status = ST_BADPRIO;
			end else if (closed_q) begin
				r.status = ST_CLOSED;
			end else if (count_q >= SLOTS) begin
				r.status = ST_FULL;
			end else begin
				pos = tail_q;
				prev = pos - 4'd1;
				while (pos != head_q && slot_pri[prev] > pri) begin
					slot_id[pos] = slot_id[prev];
					slot_pri[pos] = slot_pri[prev];
					pos = prev;
					prev = pos - 4'd1;
				end
				slot_id[pos] = id;
				slot_pri[pos] = pri;
				tail_q = tail_q + 4'd1;
				count_q = count_q + 5'd1;
			end
		end else begin
			if (closed_q) begin
				r.status = ST_CLOSED;
			end else if (count_q == 5'd0) begin
				r.status = ST_EMPTY;
			end else begin
				r.id_valid = 1'b1;
				r.out_id = slot_id[head_q];
				head_q = head_q + 4'd1;
				count_q = count_q - 5'd1;
				pos = head_q;
				for (i = 0; i < count_q; i++) begin
					if (slot_pri[pos] > 4'd1)
						slot_pri[pos] = slot_pri[pos] - 4'd1;
					pos = pos + 4'd1;
				end
			end
		end
		r.occupancy = count_q;
		return r;
	endfunction

	always @(posedge clk) begin
		queue_reply_t want;
		queue_reply_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				closed_q = cfg_data;
			if (s_tvalid && s_tready)
				awaited_replies.push_back(predict_queue_op(cmd_t'(s_tuser),
					s_tdata[9:0], s_tdata[13:10]));
			if (m_tvalid && m_tready) begin
				got.id_valid = m_tuser;
				got.out_id = m_tdata[9:0];
				got.status = status_t'(m_tdata[12:10]);
				got.occupancy = m_tdata[17:13];
				if (awaited_replies.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("unexpected result: id_valid %0d out_id %0d status %0d occ %0d",
							got.id_valid, got.out_id, got.status, got.occupancy);
				end else begin
					want = awaited_replies.pop_front();
					if (got.id_valid !== want.id_valid || got.out_id !== want.out_id ||
							got.status !== want.status || got.occupancy !== want.occupancy) begin
						fail_count++;
						if (fail_count <= REPORT_MAX)
							$display("mismatch: expected id_valid %0d out_id %0d status %0d occ %0d, got id_valid %0d out_id %0d status %0d occ %0d",
								want.id_valid, want.out_id, want.status, want.occupancy,
								got.id_valid, got.out_id, got.status, got.occupancy);
					end
				end
			end
		end
		fails <= fail_count;
		pending <= awaited_replies.size();
	end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Aging priority queue testbench
// Drives directed and random insert/retrieve transactions with random gaps
// and result stalls, toggles the closed register between phases, and reports
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import apq_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RESET_CYCLES = 4;
	localparam int PHASES = 9;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tuser;

	int          fails;
	int          pending;
	int          cycle_count = 0;
	bit          no_idle = 1'b0;

	logic [3:0]  fill_pri [16] = '{4'd15, 4'd1, 4'd15, 4'd7, 4'd1, 4'd7, 4'd3, 4'd15,
		4'd1, 4'd9, 4'd2, 4'd7, 4'd15, 4'd1, 4'd4, 4'd3};

	always #4 clk = ~clk;

	aging_priority_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	apq_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.fails     (fails),
		.pending   (pending)
	);

	task automatic send_command(cmd_t cmd, logic [9:0] id, logic [3:0] pri);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {2'b00, pri, id};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_idle;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_closed(logic value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		do begin
			@(posedge clk);
			cycle_count++;
		end while (cycle_count < CYCLE_LIMIT);
		$display("FAIL");
		$finish;
	end

	initial begin
		int   i;
		int   phase;
		int   n_items;
		int   insert_pct;
		logic closed_v;
		cmd_t cmd;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_closed(1'b0);
		send_command(CMD_RETRIEVE, 10'd0, 4'd0);
		send_command(CMD_INSERT, 10'd5, 4'd0);
		for (i = 0; i < 16; i++)
			send_command(CMD_INSERT, (i == 0) ? 10'd1023 : 10'(i * 37), fill_pri[i]);
		send_command(CMD_INSERT, 10'd1023, 4'd15);
		for (i = 0; i < 4; i++)
			send_command(CMD_RETRIEVE, 10'd1023, 4'd15);
		s_tvalid <= 1'b0;

		write_closed(1'b1);
		send_command(CMD_INSERT, 10'd3, 4'd2);
		send_command(CMD_INSERT, 10'd3, 4'd0);
		send_command(CMD_RETRIEVE, 10'd0, 4'd1);
		s_tvalid <= 1'b0;

		for (phase = 0; phase < PHASES; phase++) begin
			closed_v = (phase == 2 || phase == 6);
			no_idle = (phase % 4 == 1);
			write_closed(closed_v);
			n_items = closed_v ? 40 : 215;
			insert_pct = (phase == 0) ? 80 : $urandom_range(25, 75);
			for (i = 0; i < n_items; i++) begin
				cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_RETRIEVE;
				send_command(cmd, 10'($urandom_range(0, 1023)),
					($urandom_range(0, 19) == 0) ? 4'd0 : 4'($urandom_range(1, 15)));
			end
			s_tvalid <= 1'b0;
		end

		no_idle = 1'b0;
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
